>>> hw/rtl/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants for the chained hash table engine.
// ----------------------------------------------------------------------------
package cht_pkg;

   localparam int MaxBuckets = 256;
   localparam int Entries    = 1024;
   localparam int DataBits   = 32;

   localparam int BktW   = $clog2(MaxBuckets);      // bucket index
   localparam int BcntW  = $clog2(MaxBuckets + 1);  // bucket count
   localparam int EntW   = $clog2(Entries);         // entry index
   localparam int LinkW  = $clog2(Entries + 1);     // link incl. nil code
   localparam int CfgW   = 9;

   localparam logic [LinkW-1:0] Nil = LinkW'(Entries);

   typedef enum logic [2:0] {
      KIND_ADD     = 3'd0,
      KIND_REMOVE  = 3'd1,
      KIND_SET     = 3'd2,
      KIND_FIND    = 3'd3,
      KIND_RESTART = 3'd4,
      KIND_NEXT    = 3'd5,
      KIND_CLEAR   = 3'd6,
      KIND_NONE    = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOTFOUND = 3'd1,
      ST_FULL     = 3'd2,
      ST_DUP      = 3'd3,
      ST_DONE     = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_CLEAR,     // sweep heads and free links
      S_IDLE,
      S_MOD,       // shift-subtract hash reduction
      S_HEAD_RD,   // read chain head
      S_HEAD_WT,
      S_WALK_RD,   // read entry at walk pointer
      S_WALK_WT,
      S_WALK_CHK,
      S_ADD_WR,
      S_REM_WR,
      S_REM_FREE,  // push removed entry onto free list
      S_NEXT_RD,
      S_NEXT_WT,
      S_NEXT_CHK,
      S_OUT_RD,
      S_OUT_WT,
      S_RESP
   } state_type;

endpackage

>>> hw/rtl/chained_hash_table_engine.sv
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// Hash table with a fixed entry pool, chained buckets and a free list.
// ----------------------------------------------------------------------------
//  channel | direction | beat contents
//  req_    | in        | kind, key, key_hash, payload
//  rsp_    | out       | status, found_key, found_data
//  csr_    | in        | buckets_in_use (clears the table)
//
// An add, remove, set or find item is accepted, runs the hash reduction (one
// remainder bit a cycle in a shared subtractor), reads the chain head and
// visits the chain entry by entry, then waits in the result stage; an add of
// a new key with a free entry first writes it, a remove that finds its key first
// unlinks and frees it. Iteration next skips the reduction and scans heads bucket
// by bucket; restart and none go straight to the result stage. After reset, a
// clear item or a csr_ write the block sweeps all entries, one a cycle, and
// accepts no item meanwhile. The result waits in an output register; no item is taken until it leaves.
module chained_hash_table_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_kind,
   input  logic [31:0]               req_key,
   input  logic [31:0]               req_key_hash,
   input  logic [31:0]               req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_status,
   output logic [31:0]               rsp_found_key,
   output logic [31:0]               rsp_found_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [cht_pkg::CfgW-1:0]  csr_data
);
   import cht_pkg::*;

   // memories
   logic [LinkW-1:0]    heads_mem [MaxBuckets];
   logic [LinkW-1:0]    links_mem [Entries];
   logic [31:0]         keys_mem  [Entries];
   logic [31:0]         hashes_mem[Entries];
   logic [DataBits-1:0] data_mem  [Entries];

   state_type state_ff, state_in;

   kind_type            kind_ff, kind_in;
   logic [31:0]         key_ff, key_in, hash_ff, hash_in;
   logic [DataBits-1:0] pay_ff, pay_in;
   logic [BcntW-1:0]    nb_ff, nb_in;       // active bucket count
   logic [CfgW-1:0]     cfg_ff, cfg_in;
   logic [BcntW:0]      rem_ff, rem_in;     // reduction remainder
   logic [5:0]          bit_ff, bit_in;
   logic [BktW-1:0]     bkt_ff, bkt_in;
   logic [LinkW-1:0]    cur_ff, cur_in, prev_ff, prev_in;
   logic [LinkW-1:0]    free_ff, free_in;
   logic [BcntW-1:0]    cb_ff, cb_in;       // cursor bucket
   logic [LinkW-1:0]    ce_ff, ce_in;       // cursor entry
   logic [LinkW-1:0]    clr_ff, clr_in;
   logic                clr_rsp_ff, clr_rsp_in;  // sweep answers a clear item
   logic                rv_ff, rv_in;
   logic [2:0]          st_ff, st_in;
   logic [31:0]         ok_ff, ok_in, od_ff, od_in;

   // registered read data
   logic [LinkW-1:0]    head_rd, link_rd;
   logic [31:0]         key_rd, hash_rd;
   logic [DataBits-1:0] data_rd;

   // memory request strobes
   logic [BktW-1:0]     head_raddr, head_waddr;
   logic [EntW-1:0]     ent_raddr;
   logic                head_we, link_we, ent_we, data_we;
   logic [LinkW-1:0]    head_wdata, link_wdata;
   logic [EntW-1:0]     link_waddr, ent_waddr;
   logic [DataBits-1:0] data_wdata;

   logic [BcntW:0]      rem_shift;
   logic [BcntW-1:0]    cfg_clip;

   // clipped register value
   always_comb begin
      if (cfg_ff == '0)
         cfg_clip = BcntW'(1);
      else if (32'(cfg_ff) > 32'(MaxBuckets))
         cfg_clip = BcntW'(MaxBuckets);
      else
         cfg_clip = BcntW'(cfg_ff);
   end

   // memory ports
   always_ff @(posedge clock) begin
      head_rd <= heads_mem[head_raddr];
      link_rd <= links_mem[ent_raddr];
      key_rd  <= keys_mem[ent_raddr];
      hash_rd <= hashes_mem[ent_raddr];
      data_rd <= data_mem[ent_raddr];
      if (head_we) heads_mem[head_waddr] <= head_wdata;
      if (link_we) links_mem[link_waddr] <= link_wdata;
      if (ent_we) begin
         keys_mem[ent_waddr]   <= key_ff;
         hashes_mem[ent_waddr] <= hash_ff;
      end
      if (data_we) data_mem[ent_waddr] <= data_wdata;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         cfg_ff     <= CfgW'(MaxBuckets);
         rv_ff      <= 1'b0;
         clr_ff     <= '0;
         clr_rsp_ff <= 1'b0;
         free_ff    <= LinkW'(Entries - 1);
         cb_ff      <= '0;
         ce_ff      <= Nil;
      end else begin
         state_ff   <= state_in;
         cfg_ff     <= cfg_in;
         rv_ff      <= rv_in;
         clr_ff     <= clr_in;
         clr_rsp_ff <= clr_rsp_in;
         free_ff    <= free_in;
         cb_ff      <= cb_in;
         ce_ff      <= ce_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in; key_ff <= key_in; hash_ff <= hash_in; pay_ff <= pay_in;
      nb_ff <= nb_in; rem_ff <= rem_in; bit_ff <= bit_in; bkt_ff <= bkt_in;
      cur_ff <= cur_in; prev_ff <= prev_in;
      st_ff <= st_in; ok_ff <= ok_in; od_ff <= od_in;
   end

   assign rem_shift = {rem_ff[BcntW-1:0], hash_ff[bit_ff[4:0]]};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == LinkW'(Entries - 1)) state_in = clr_rsp_ff ? S_RESP : S_IDLE;
         end
         S_IDLE: begin
            if (csr_valid) state_in = S_CLEAR;
            else if (req_valid) begin
               case (kind_type'(req_kind))
                  KIND_CLEAR:   state_in = S_CLEAR;
                  KIND_RESTART: state_in = S_RESP;
                  KIND_NONE:    state_in = S_RESP;
                  KIND_NEXT:    state_in = S_NEXT_CHK;
                  default:      state_in = S_MOD;
               endcase
            end
         end
         S_MOD:      if (bit_ff == 6'd0) state_in = S_HEAD_RD;
         S_HEAD_RD:  state_in = S_HEAD_WT;
         S_HEAD_WT:  state_in = S_WALK_CHK;
         S_WALK_RD:  state_in = S_WALK_WT;
         S_WALK_WT:  state_in = S_WALK_CHK;
         S_WALK_CHK: begin
            if (cur_ff == Nil) begin
               if (kind_ff == KIND_ADD && free_ff != Nil) state_in = S_ADD_WR;
               else state_in = S_RESP;
            end else if (prev_ff == cur_ff) begin
               // entry data now valid
               if ((kind_ff == KIND_REMOVE && key_rd == key_ff) ||
                   (kind_ff != KIND_REMOVE && key_rd == key_ff && hash_rd == hash_ff)) begin
                  if (kind_ff == KIND_REMOVE) state_in = S_REM_WR;
                  else state_in = S_RESP;
               end else state_in = S_WALK_CHK;
            end else state_in = S_WALK_RD;
         end
         S_ADD_WR:   state_in = S_RESP;
         S_REM_WR:   state_in = S_REM_FREE;
         S_REM_FREE: state_in = S_RESP;
         S_NEXT_CHK: begin
            if (cur_ff != Nil) state_in = S_NEXT_CHK;
            else if (ce_ff != Nil) state_in = S_OUT_RD;
            else if (cb_ff < nb_ff) state_in = S_NEXT_RD;
            else state_in = S_RESP;
         end
         S_NEXT_RD:  state_in = S_NEXT_WT;
         S_NEXT_WT:  state_in = S_NEXT_CHK;
         S_OUT_RD:   state_in = S_OUT_WT;
         S_OUT_WT:   state_in = S_RESP;
         S_RESP:     if (!rv_ff || rsp_ready) state_in = rv_ff ? S_IDLE : S_RESP;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cfg_in = cfg_ff; rv_in = rv_ff; clr_in = clr_ff; free_in = free_ff;
      clr_rsp_in = clr_rsp_ff;
      cb_in = cb_ff; ce_in = ce_ff;
      kind_in = kind_ff; key_in = key_ff; hash_in = hash_ff; pay_in = pay_ff;
      nb_in = nb_ff; rem_in = rem_ff; bit_in = bit_ff; bkt_in = bkt_ff;
      cur_in = cur_ff; prev_in = prev_ff; st_in = st_ff; ok_in = ok_ff; od_in = od_ff;
      head_raddr = bkt_ff; head_waddr = bkt_ff; head_we = 1'b0; head_wdata = Nil;
      ent_raddr = cur_ff[EntW-1:0]; link_we = 1'b0; link_waddr = clr_ff[EntW-1:0];
      link_wdata = Nil; ent_we = 1'b0; data_we = 1'b0;
      ent_waddr = cur_ff[EntW-1:0]; data_wdata = pay_ff;
      req_ready = 1'b0; csr_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            // sweep free links and chain heads, one entry a cycle
            link_we = 1'b1;
            link_waddr = clr_ff[EntW-1:0];
            link_wdata = (clr_ff == '0) ? Nil : clr_ff - LinkW'(1);
            if (32'(clr_ff) < 32'(MaxBuckets)) begin
               head_we = 1'b1;
               head_waddr = clr_ff[BktW-1:0];
            end
            clr_in = clr_ff + LinkW'(1);
            free_in = LinkW'(Entries - 1);
            cb_in = '0; ce_in = Nil;
            if (clr_ff == LinkW'(Entries - 1)) clr_in = '0;
         end
         S_IDLE: begin
            csr_ready = 1'b1;
            req_ready = !csr_valid;
            if (csr_valid) begin
               cfg_in = csr_data;
               clr_in = '0;
               clr_rsp_in = 1'b0;
            end else if (req_valid) begin
               kind_in = kind_type'(req_kind);
               key_in = req_key; hash_in = req_key_hash;
               pay_in = DataBits'(req_payload);
               nb_in = cfg_clip; rem_in = '0; bit_in = 6'd31;
               st_in = ST_OK; ok_in = '0; od_in = '0;
               clr_in = '0;
               clr_rsp_in = (req_kind == KIND_CLEAR);
               if (req_kind == KIND_ADD || req_kind == KIND_REMOVE ||
                   req_kind == KIND_RESTART) begin
                  cb_in = '0; ce_in = Nil;
               end
               // advance cursor off the current entry
               if (req_kind == KIND_NEXT) begin
                  ent_raddr = ce_ff[EntW-1:0];
               end
               if (req_kind == KIND_NEXT && ce_ff != Nil) begin
                  cur_in = ce_ff; ce_in = Nil; prev_in = Nil;
                  // link read arrives next cycle; handled in S_NEXT_CHK
               end else cur_in = Nil;
               if (req_kind == KIND_CLEAR) rv_in = 1'b0;
            end
         end
         S_MOD: begin
            // one remainder bit a cycle
            if (rem_shift >= {1'b0, nb_ff}) rem_in = rem_shift - {1'b0, nb_ff};
            else rem_in = rem_shift;
            bit_in = bit_ff - 6'd1;
            if (bit_ff == 6'd0) bkt_in = (rem_shift >= {1'b0, nb_ff}) ?
               BktW'(rem_shift - {1'b0, nb_ff}) : BktW'(rem_shift);
         end
         S_HEAD_RD: head_raddr = bkt_ff;
         S_HEAD_WT: begin
            cur_in = head_rd; prev_in = Nil;
         end
         S_WALK_RD: ent_raddr = cur_ff[EntW-1:0];
         S_WALK_WT: begin
            // mark entry data valid by prev==cur, keep real prev in ok_ff
            ok_in = 32'(prev_ff);
            prev_in = cur_ff;
         end
         S_WALK_CHK: begin
            if (cur_ff == Nil) begin
               if (kind_ff == KIND_ADD) begin
                  if (free_ff == Nil) st_in = ST_FULL;
                  else ent_raddr = free_ff[EntW-1:0];
               end else if (kind_ff != KIND_ADD) st_in = ST_NOTFOUND;
               ok_in = '0;
            end else if (prev_ff == cur_ff) begin
               if (kind_ff == KIND_REMOVE && key_rd == key_ff) begin
                  prev_in = LinkW'(ok_ff);
               end else if (kind_ff != KIND_REMOVE && key_rd == key_ff &&
                            hash_rd == hash_ff) begin
                  case (kind_ff)
                     KIND_ADD: st_in = ST_DUP;
                     KIND_SET: begin
                        data_we = 1'b1; ent_waddr = cur_ff[EntW-1:0];
                     end
                     KIND_FIND: od_in = 32'(data_rd);
                     default: ;
                  endcase
                  ok_in = (kind_ff == KIND_FIND) ? key_rd : '0;
               end else begin
                  prev_in = cur_ff;
                  ok_in = 32'(cur_ff);
                  cur_in = link_rd;
               end
            end
         end
         S_ADD_WR: begin
            // pop free list (link read issued last cycle)
            ent_waddr = free_ff[EntW-1:0];
            ent_we = 1'b1; data_we = 1'b1;
            link_we = 1'b1; link_waddr = free_ff[EntW-1:0]; link_wdata = head_rd;
            head_we = 1'b1; head_wdata = free_ff;
            free_in = link_rd;
            ok_in = '0;
         end
         S_REM_WR: begin
            // unlink the entry from its chain
            if (prev_ff == Nil) begin
               head_we = 1'b1; head_wdata = link_rd;
            end else begin
               link_we = 1'b1; link_waddr = prev_ff[EntW-1:0]; link_wdata = link_rd;
            end
            ok_in = '0;
         end
         S_REM_FREE: begin
            link_we = 1'b1; link_waddr = cur_ff[EntW-1:0]; link_wdata = free_ff;
            free_in = cur_ff;
         end
         S_NEXT_CHK: begin
            if (cur_ff != Nil) begin
               // link of previous cursor entry now in link_rd
               ce_in = link_rd; cur_in = Nil;
            end else if (ce_ff != Nil) begin
               ent_raddr = ce_ff[EntW-1:0];
            end else if (cb_ff >= nb_ff) begin
               st_in = ST_DONE;
            end
         end
         S_NEXT_RD: head_raddr = BktW'(cb_ff);
         S_NEXT_WT: begin
            ce_in = head_rd; cb_in = cb_ff + BcntW'(1);
         end
         S_OUT_RD: ent_raddr = ce_ff[EntW-1:0];
         S_OUT_WT: begin
            ok_in = key_rd; od_in = 32'(data_rd);
         end
         S_RESP: begin
            if (!rv_ff) rv_in = 1'b1;
            else if (rsp_ready) rv_in = 1'b0;
         end
         default: ;
      endcase
   end

   assign rsp_valid      = rv_ff && state_ff == S_RESP;
   assign rsp_status     = st_ff;
   assign rsp_found_key  = ok_ff;
   assign rsp_found_data = od_ff;

endmodule

>>> tb/tb_chained_hash_table_engine.sv
// ----------------------------------------------------------------------------
// tb_chained_hash_table_engine
// Self-checking bench for the chained hash table engine: a local table model
// predicts every response; requests and responses move on valid/ready with
// random gaps, a long response hold-off and several bucket-count settings.
// ----------------------------------------------------------------------------
module tb_chained_hash_table_engine;
   import cht_pkg::*;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] key;
      logic [31:0] key_hash;
      logic [31:0] payload;
   } op_beat_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] found_key;
      logic [31:0] found_data;
   } answer_type;

   localparam int WatchLimit = 200000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [2:0]        req_kind;
   logic [31:0]       req_key;
   logic [31:0]       req_key_hash;
   logic [31:0]       req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [2:0]        rsp_status;
   logic [31:0]       rsp_found_key;
   logic [31:0]       rsp_found_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [CfgW-1:0]   csr_data;

   // table model
   int unsigned heads [MaxBuckets];
   int unsigned links [Entries];
   logic [31:0] keys_m [Entries];
   logic [31:0] hashes_m [Entries];
   logic [31:0] data_m [Entries];
   int unsigned free_top;
   int unsigned cur_bkt;
   int unsigned cur_ent;
   int unsigned nbuckets;

   op_beat_type pending_ops[$];
   answer_type  expected_answers[$];
   logic [31:0] live_keys[$];
   logic [31:0] live_hashes[$];

   int  mismatches;
   int  answers_seen;
   int  idle_cycles;
   int  req_gap;
   int  rsp_gap;
   int  hold_off;
   bit  stimulus_done;
   bit  cfg_pending;
   logic [CfgW-1:0] cfg_value;

   chained_hash_table_engine i_dut (.*);

   // clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic void model_clear();
      for (int i = 0; i < MaxBuckets; i++) heads[i] = Entries;
      for (int i = 0; i < Entries; i++) begin
         links[i] = (i == 0) ? Entries : i - 1;
         keys_m[i] = '0;
         hashes_m[i] = '0;
         data_m[i] = '0;
      end
      free_top = Entries - 1;
      cur_bkt = 0;
      cur_ent = Entries;
      live_keys.delete();
      live_hashes.delete();
   endfunction

   function automatic void model_set_buckets(logic [CfgW-1:0] v);
      nbuckets = (v == 0) ? 1 : (v > MaxBuckets) ? MaxBuckets : v;
      model_clear();
   endfunction

   function automatic int unsigned find_entry(logic [31:0] k, logic [31:0] h);
      int unsigned e;
      e = heads[h % nbuckets];
      while (e < Entries) begin
         if (hashes_m[e] == h && keys_m[e] == k) return e;
         e = links[e];
      end
      return Entries;
   endfunction

   function automatic answer_type table_predict(op_beat_type op);
      answer_type  a;
      int unsigned b;
      int unsigned e;
      int unsigned prev;
      a = '{ST_OK, 32'd0, 32'd0};
      case (op.kind)
         KIND_ADD: begin
            cur_bkt = 0; cur_ent = Entries;
            if (find_entry(op.key, op.key_hash) < Entries) a.status = ST_DUP;
            else if (free_top >= Entries) a.status = ST_FULL;
            else begin
               b = op.key_hash % nbuckets;
               e = free_top;
               free_top = links[e];
               keys_m[e] = op.key;
               hashes_m[e] = op.key_hash;
               data_m[e] = op.payload;
               links[e] = heads[b];
               heads[b] = e;
               live_keys.push_back(op.key);
               live_hashes.push_back(op.key_hash);
            end
         end
         KIND_REMOVE: begin
            cur_bkt = 0; cur_ent = Entries;
            b = op.key_hash % nbuckets;
            prev = Entries;
            e = heads[b];
            while (e < Entries && keys_m[e] != op.key) begin
               prev = e;
               e = links[e];
            end
            if (e >= Entries) a.status = ST_NOTFOUND;
            else begin
               if (prev < Entries) links[prev] = links[e];
               else heads[b] = links[e];
               links[e] = free_top;
               free_top = e;
            end
         end
         KIND_SET: begin
            e = find_entry(op.key, op.key_hash);
            if (e < Entries) data_m[e] = op.payload;
            else a.status = ST_NOTFOUND;
         end
         KIND_FIND: begin
            e = find_entry(op.key, op.key_hash);
            if (e < Entries) begin
               a.found_key = keys_m[e];
               a.found_data = data_m[e];
            end else a.status = ST_NOTFOUND;
         end
         KIND_RESTART: begin
            cur_bkt = 0; cur_ent = Entries;
         end
         KIND_NEXT: begin
            if (cur_ent < Entries) cur_ent = links[cur_ent];
            while (cur_ent >= Entries && cur_bkt < nbuckets) begin
               cur_ent = heads[cur_bkt];
               cur_bkt++;
            end
            if (cur_ent < Entries) begin
               a.found_key = keys_m[cur_ent];
               a.found_data = data_m[cur_ent];
            end else begin
               cur_ent = Entries;
               a.status = ST_DONE;
            end
         end
         KIND_CLEAR: model_clear();
         default: ;
      endcase
      return a;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h want %h (answer %0d)", what, got, want, answers_seen);
      mismatches++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (req_valid && !req_ready) begin
      end else if (req_gap > 0) begin
         req_gap <= req_gap - 1;
         req_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
         req_valid <= 1'b1;
         req_kind <= pending_ops[0].kind;
         req_key <= pending_ops[0].key;
         req_key_hash <= pending_ops[0].key_hash;
         req_payload <= pending_ops[0].payload;
         expected_answers.push_back(table_predict(pending_ops[0]));
         void'(pending_ops.pop_front());
         req_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      end else req_valid <= 1'b0;
   end

   // config write driver
   always @(posedge clock) begin
      if (reset) csr_valid <= 1'b0;
      else if (csr_valid && csr_ready) begin
         csr_valid <= 1'b0;
         cfg_pending <= 1'b0;
      end else if (cfg_pending && !csr_valid) begin
         csr_valid <= 1'b1;
         csr_data <= cfg_value;
      end
   end

   // response monitor with random and long stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            answers_seen++;
            if (expected_answers.size() == 0) begin
               $display("unexpected response beat %0d", answers_seen);
               mismatches++;
            end else begin
               if (rsp_status != expected_answers[0].status)
                  report_mismatch("status", rsp_status, expected_answers[0].status);
               if (rsp_found_key != expected_answers[0].found_key)
                  report_mismatch("found_key", rsp_found_key, expected_answers[0].found_key);
               if (rsp_found_data != expected_answers[0].found_data)
                  report_mismatch("found_data", rsp_found_data,
                                  expected_answers[0].found_data);
               void'(expected_answers.pop_front());
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            rsp_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            rsp_ready <= (rsp_gap == 0);
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else rsp_ready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || hold_off > 0)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic push_op(kind_type k, logic [31:0] key, logic [31:0] h, logic [31:0] p);
      op_beat_type op;
      op = '{k, key, h, p};
      pending_ops.push_back(op);
   endtask

   task automatic drain();
      wait (pending_ops.size() == 0 && !req_valid && expected_answers.size() == 0);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_buckets(logic [CfgW-1:0] v);
      drain();
      @(posedge clock);
      cfg_value <= v;
      cfg_pending <= 1'b1;
      model_set_buckets(v);
      wait (cfg_pending == 1'b1);
      wait (cfg_pending == 1'b0);
      @(posedge clock);
   endtask

   // random burst, mostly ops on keys that exist or collide
   task automatic random_phase(int n);
      logic [31:0] k;
      logic [31:0] h;
      int          sel;
      int unsigned r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (live_keys.size() > 0 && $urandom_range(0, 2) != 0) begin
            sel = $urandom_range(0, live_keys.size() - 1);
            k = live_keys[sel];
            h = live_hashes[sel];
            if ($urandom_range(0, 9) == 0) h = h ^ (32'd1 << $urandom_range(0, 31));
         end else begin
            k = ($urandom_range(0, 1)) ? $urandom() : $urandom_range(0, 15);
            h = ($urandom_range(0, 1)) ? $urandom() : $urandom_range(0, 40);
         end
         if (r < 35) push_op(KIND_ADD, k, h, $urandom());
         else if (r < 50) push_op(KIND_REMOVE, k, h, $urandom());
         else if (r < 62) push_op(KIND_SET, k, h, $urandom());
         else if (r < 78) push_op(KIND_FIND, k, h, $urandom());
         else if (r < 82) push_op(KIND_RESTART, $urandom(), $urandom(), $urandom());
         else if (r < 97) push_op(KIND_NEXT, $urandom(), $urandom(), $urandom());
         else if (r < 98) push_op(KIND_CLEAR, $urandom(), $urandom(), $urandom());
         else push_op(KIND_NONE, $urandom(), $urandom(), $urandom());
         if (pending_ops.size() > 8) wait (pending_ops.size() < 4);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_kind = '0; req_key = '0; req_key_hash = '0; req_payload = '0;
      rsp_ready = 1'b0; csr_valid = 1'b0; csr_data = '0;
      mismatches = 0; answers_seen = 0; idle_cycles = 0; hold_off = 0;
      cfg_pending = 1'b0; stimulus_done = 1'b0;
      model_set_buckets(CfgW'(MaxBuckets));
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every kind, duplicate, missing, iteration end
      push_op(KIND_NEXT, 0, 0, 0);
      push_op(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_op(KIND_ADD, 32'h0, 32'h0, 32'h0);
      push_op(KIND_ADD, 32'h0, 32'h0, 32'h1234);
      push_op(KIND_ADD, 32'h5, 32'h100, 32'hA5A5_5A5A);
      push_op(KIND_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      push_op(KIND_FIND, 32'h5, 32'h101, 0);
      push_op(KIND_SET, 32'h5, 32'h100, 32'h5A5A_A5A5);
      push_op(KIND_SET, 32'h6, 32'h100, 32'h1);
      push_op(KIND_RESTART, 0, 0, 0);
      repeat (4) push_op(KIND_NEXT, 0, 0, 0);
      push_op(KIND_NEXT, 0, 0, 0);
      push_op(KIND_REMOVE, 32'h5, 32'h0, 0);
      push_op(KIND_REMOVE, 32'h5, 32'h100, 0);
      push_op(KIND_REMOVE, 32'h7, 32'h100, 0);
      push_op(KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_op(KIND_CLEAR, 0, 0, 0);
      push_op(KIND_FIND, 0, 0, 0);

      // long response hold-off while requests keep coming
      drain();
      hold_off = 300;
      for (int i = 0; i < 10; i++) push_op(KIND_ADD, i, i * 7, $urandom());
      drain();

      random_phase(200);
      write_buckets(CfgW'(1));
      random_phase(150);
      write_buckets(CfgW'(0));
      random_phase(100);
      write_buckets(CfgW'(511));
      random_phase(120);
      write_buckets(CfgW'(3));
      random_phase(60);
      write_buckets(CfgW'(256));
      random_phase(240);

      drain();
      stimulus_done = 1'b1;
      $display("covered all op kinds, bucket counts 1/0/511/3/256 and long stalls");
      $display("%0d responses checked, %0d mismatches", answers_seen, mismatches);
      if (mismatches == 0 && expected_answers.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
